// File: rtl/core/mcu_pkg.sv
// Shared types and constants for the max-min closure update unit.
// Holds the command and result word layouts, opcodes, FSM states and memory control.
// No dependencies.
package mcu_pkg;

	// Width of one stored bottleneck value
	localparam int ValW = 30;

	// Values at or above this count as unreachable (infinite)
	localparam logic [ValW-1:0] InfValue = 30'd1000000001;

	// Command opcodes
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} mcu_op_t;

	// Command word
	typedef struct packed {
		logic [1:0]      opcode;
		logic [7:0]      row_index;
		logic [7:0]      col_index;
		logic [ValW-1:0] entry_value;
	} mcu_cmd_t;

	// Result word
	typedef struct packed {
		logic [ValW-1:0] entry_out;
		logic            update_skipped;
		logic            bad_index;
	} mcu_res_t;

	// Memory port strobes
	typedef struct packed {
		logic re;
		logic we;
	} mcu_mem_ctl_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PIVOT,
		ST_SW_A,
		ST_SW_B,
		ST_SW_C,
		ST_SW_W
	} mcu_state_t;

endpackage

// File: rtl/core/mcu_matrix_ram.sv
// Single-port synchronous RAM holding the bottleneck matrix, with a registered read port.
// Depends on mcu_pkg for the value width and memory strobe struct.
module mcu_matrix_ram #(
	parameter int AW = 16
) (
	input  logic                        clk,
	input  mcu_pkg::mcu_mem_ctl_t       ctl,
	input  logic [AW-1:0]               addr,
	input  logic [mcu_pkg::ValW-1:0]    wdata,
	output logic [mcu_pkg::ValW-1:0]    rdata
);
	import mcu_pkg::*;

	logic [ValW-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: rtl/core/mcu_sweep_ctrl.sv
// Command sequencer: single entry access, pivot check and in-place max-min sweep.
// Depends on mcu_pkg; drives the port of mcu_matrix_ram.
module mcu_sweep_ctrl #(
	parameter int IW = 8,
	parameter int SW = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  mcu_pkg::mcu_cmd_t           cmd,
	input  logic [SW-1:0]               size,
	output logic                        busy,
	output mcu_pkg::mcu_mem_ctl_t       mem_ctl,
	output logic [2*IW-1:0]             mem_addr,
	output logic [mcu_pkg::ValW-1:0]    mem_wdata,
	input  logic [mcu_pkg::ValW-1:0]    mem_rdata,
	output logic                        res_valid,
	output mcu_pkg::mcu_res_t           res
);
	import mcu_pkg::*;

	mcu_state_t      state_q, state_d;
	mcu_cmd_t        cmd_q;
	logic [IW-1:0]   i_q, j_q;
	logic [ValW-1:0] a_s2, b_s3;
	logic            accept, bad_in;
	logic            last_col, last_row, last_elem;
	logic [ValW-1:0] lo;
	logic [IW-1:0]   x_idx, y_idx;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Index check against the active square
	assign bad_in = (SW'(cmd.row_index) >= size) || (SW'(cmd.col_index) >= size);

	assign x_idx = IW'(cmd_q.row_index);
	assign y_idx = IW'(cmd_q.col_index);

	// Sweep position
	assign last_col  = (SW'(j_q) == size - 1'b1);
	assign last_row  = (SW'(i_q) == size - 1'b1);
	assign last_elem = last_col && last_row;

	// Candidate value: min of the pivot column and pivot row entries
	assign lo = (a_s2 < b_s3) ? a_s2 : b_s3;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !bad_in) begin
					unique case (cmd.opcode)
						OP_READ:   state_d = ST_READ;
						OP_UPDATE: state_d = ST_PIVOT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_PIVOT: state_d = (mem_rdata >= InfValue) ? ST_IDLE : ST_SW_A;
			ST_SW_A:  state_d = ST_SW_B;
			ST_SW_B:  state_d = ST_SW_C;
			ST_SW_C:  state_d = ST_SW_W;
			ST_SW_W:  state_d = last_elem ? ST_IDLE : ST_SW_A;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory requests and the result word
	always_comb begin
		mem_ctl   = '0;
		mem_addr  = '0;
		mem_wdata = lo;
		res_valid = 1'b0;
		res       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.opcode == OP_NONE) begin
						res_valid = 1'b1;
					end else if (bad_in) begin
						res_valid     = 1'b1;
						res.bad_index = 1'b1;
					end else begin
						mem_addr = {IW'(cmd.row_index), IW'(cmd.col_index)};
						unique case (cmd.opcode)
							OP_WRITE: begin
								mem_ctl.we = 1'b1;
								mem_wdata  = cmd.entry_value;
								res_valid  = 1'b1;
							end
							default: mem_ctl.re = 1'b1;
						endcase
					end
				end
			end
			ST_READ: begin
				res_valid     = 1'b1;
				res.entry_out = mem_rdata;
			end
			ST_PIVOT: begin
				if (mem_rdata >= InfValue) begin
					res_valid          = 1'b1;
					res.update_skipped = 1'b1;
				end
			end
			ST_SW_A: begin
				mem_ctl.re = 1'b1;
				mem_addr   = {i_q, x_idx};
			end
			ST_SW_B: begin
				mem_ctl.re = 1'b1;
				mem_addr   = {y_idx, j_q};
			end
			ST_SW_C: begin
				mem_ctl.re = 1'b1;
				mem_addr   = {i_q, j_q};
			end
			ST_SW_W: begin
				mem_ctl.we = (lo > mem_rdata);
				mem_addr   = {i_q, j_q};
				res_valid  = last_elem;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// State and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				i_q <= '0;
				j_q <= '0;
			end else if (state_q == ST_SW_W) begin
				if (last_col) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// Command latch and operand capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SW_B) begin
			a_s2 <= mem_rdata;
		end
		if (state_q == ST_SW_C) begin
			b_s3 <= mem_rdata;
		end
	end

endmodule

// File: rtl/core/maxmin_closure_update_unit.sv
// Top level of the max-min closure update unit: node count register, result word
// register and assertions. Depends on mcu_pkg, mcu_sweep_ctrl and mcu_matrix_ram.
//
// Usage
//   A command word on cmd is taken at a rising edge with start high and busy low.
//   Every command gives exactly one result word on result, shown for one cycle
//   with result_valid high; the receiver has no way to stall it. The user writes
//   node_count via cfg_we/cfg_wdata only while busy is low; no logic enforces it.
// Source of result_valid (always through the result word register)
//   write, unused opcode, bad index : from the accepting cycle in ST_IDLE
//   read                           : from ST_READ
//   skipped update                 : from ST_PIVOT
//   update : from the last ST_SW_W; S*S entries, S = min(2*node_count, DIM)
//   Each swept entry needs three reads and a conditional write on the one RAM
//   port, so the single-port matrix RAM sets the update time. A new command can
//   be taken in the cycle busy falls, while the previous result is still shown.
// Reset
//   Clears the sequencer and sets node_count to 1. The matrix is not cleared;
//   entries are undefined until written.
module maxmin_closure_update_unit #(
	parameter int DIM = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mcu_pkg::mcu_cmd_t    cmd,
	output logic                 result_valid,
	output mcu_pkg::mcu_res_t    result,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	import mcu_pkg::*;

	localparam int IW = $clog2(DIM);
	localparam int SW = ($clog2(DIM + 1) > 9) ? $clog2(DIM + 1) : 9;

	logic [7:0]      node_count_q;
	logic [SW-1:0]   dbl_count, size;
	mcu_mem_ctl_t    mem_ctl;
	logic [2*IW-1:0] mem_addr;
	logic [ValW-1:0] mem_wdata, mem_rdata;
	logic            res_valid;
	mcu_res_t        res;
	logic            result_valid_q;
	mcu_res_t        result_q;

	// Node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd1;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Active square side, capped at DIM
	assign dbl_count = SW'({node_count_q, 1'b0});
	assign size      = (dbl_count > SW'(DIM)) ? SW'(DIM) : dbl_count;

	mcu_sweep_ctrl #(
		.IW (IW),
		.SW (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.size      (size),
		.busy      (busy),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	mcu_matrix_ram #(
		.AW (2 * IW)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Write and unused-opcode commands answer on the next edge
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode != OP_READ && cmd.opcode != OP_UPDATE
		|=> result_valid)
		else $error("single-cycle command gave no result word");

	// A result word only follows an accepted command or busy period
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy) || $past(start))
		else $error("result word without a command");

	// Skip and bad index never together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.update_skipped && result.bad_index))
		else $error("skip and bad index flagged together");

	// The single RAM port never reads and writes in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.re && mem_ctl.we))
		else $error("RAM read and write in the same cycle");

endmodule
